### rtl/fbfla_pkg.sv
// Shared constants, codes and field widths of the fixed block free-list allocator.
package fbfla_pkg;

   // Pool geometry default; the top level takes it as a parameter.
   localparam int MAX_BLOCKS_DEF = 1024;

   // Field widths of the transactions and registers.
   localparam int COUNT_W    = 11;
   localparam int BYTES_W    = 16;
   localparam int REQ_IDX_W  = 12;
   localparam int GRANT_W    = 10;
   localparam int STATUS_W   = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register reset values.
   localparam logic [COUNT_W-1:0] COUNT_RESET  = COUNT_W'(1024);
   localparam logic [BYTES_W-1:0] USABLE_RESET = BYTES_W'(56);

   // Register select codes (byte address bit 2).
   localparam logic REG_BLOCK_COUNT = 1'b0;
   localparam logic REG_USABLE      = 1'b1;

   // Request kinds.
   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NULL_REL  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd6;

endpackage

### rtl/fixed_block_free_list_allocator.sv
// Top level of the fixed block free-list allocator: control, registers and link memory.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-------------------------------------------
//  req_     | in  | req_tvalid / req_tready      | tuser: action; tdata: request_bytes,
//           |     |                              |   release_is_null, release_index
//  rsp_     | out | rsp_tvalid / rsp_tready      | tdata: ok, granted_index, status
//  csr_     | in  | psel, penable, pwrite, pready| block_count at 0x0, usable_block_bytes at 0x4
//
// Each transaction is accepted and its result registered; after a granted allocate that leaves
// a non-empty list, requests stall until the link of the new head comes back from the link memory.
// Reset, and every write of block_count, start a rebuild pass that writes all MAX_BLOCKS
// link entries, one per cycle; no request transaction is taken while the pass runs.
// The result sits in an output register, so a new request is taken in the cycle the
// previous result leaves or while the result register is empty.
module fixed_block_free_list_allocator #(
   parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,  // request_bytes[15:0],
                                                           // release_is_null[16],
                                                           // release_index[28:17], zero pad
   input  logic                                req_tuser,  // action[0]
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // ok[0], granted_index[10:1],
                                                           // status[13:11], zero pad
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fbfla_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fbfla_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fbfla_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   import fbfla_pkg::*;

   // Block index, link (index plus a null code) and compare widths.
   localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
   localparam int EXT_W  = (LINK_W > REQ_IDX_W) ? LINK_W : REQ_IDX_W;
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_BLOCKS);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_BLOCKS - 1);

   // Registers
   logic [COUNT_W-1:0]  count_ff,        count_in;
   logic [BYTES_W-1:0]  usable_ff,       usable_in;
   logic [IDX_W-1:0]    head_ff,         head_in;
   logic                hvalid_ff,       hvalid_in;
   logic [LINK_W-1:0]   nxt_ff,          nxt_in;      // link of the current head
   logic                pend_ff,         pend_in;     // link read in flight
   logic                sweep_active_ff, sweep_active_in;
   logic [IDX_W-1:0]    sweep_ff,        sweep_in;
   logic                rsp_valid_ff,    rsp_valid_in;
   logic [15:0]         rsp_data_ff,     rsp_data_in;

   // Request fields
   logic                act;
   logic [BYTES_W-1:0]  req_bytes;
   logic                rel_null;
   logic [REQ_IDX_W-1:0] rel_idx;

   logic                accept;
   logic                cfg_wr;
   logic [EXT_W-1:0]    eff_count;
   logic [EXT_W-1:0]    sweep_next;
   logic                alloc_grant;
   logic                rel_push;
   logic                nxt_is_null;
   logic                ok;
   logic [STATUS_W-1:0] status;
   logic [LINK_W-1:0]   push_link;

   // Link memory ports
   logic                mem_wr_en;
   logic [IDX_W-1:0]    mem_wr_addr;
   logic [LINK_W-1:0]   mem_wr_data;
   logic                mem_rd_en;
   logic [IDX_W-1:0]    mem_rd_addr;
   logic [LINK_W-1:0]   mem_rd_data;

   assign act       = req_tuser;
   assign req_bytes = req_tdata[15:0];
   assign rel_null  = req_tdata[16];
   assign rel_idx   = req_tdata[28:17];

   assign cfg_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Stall while rebuilding, while the new head's link is on its way, or while the
   // result register is full and not draining.
   assign req_tready = !sweep_active_ff && !pend_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // Saturate the block count to the pool size.
   assign eff_count = (EXT_W'(count_ff) > EXT_W'(MAX_BLOCKS)) ? EXT_W'(MAX_BLOCKS)
                                                              : EXT_W'(count_ff);
   assign sweep_next  = EXT_W'(sweep_ff) + EXT_W'(1);
   assign nxt_is_null = (nxt_ff == LINK_NULL);
   assign push_link   = hvalid_ff ? LINK_W'(head_ff) : LINK_NULL;

   // Classify the request.
   always_comb begin
      alloc_grant = 1'b0;
      rel_push    = 1'b0;
      ok          = 1'b0;
      status      = ST_GRANTED;
      unique case (act)
         ACT_ALLOC: begin
            priority if (req_bytes == '0) begin
               status = ST_ZERO_SIZE;
            end else if (!hvalid_ff) begin
               status = ST_EMPTY;
            end else if (req_bytes > usable_ff) begin
               status = ST_TOO_LARGE;
            end else begin
               status      = ST_GRANTED;
               ok          = 1'b1;
               alloc_grant = accept;
            end
         end
         ACT_RELEASE: begin
            priority if (rel_null) begin
               status = ST_NULL_REL;
               ok     = 1'b1;
            end else if (EXT_W'(rel_idx) >= eff_count) begin
               status = ST_RANGE;
            end else begin
               status   = ST_RELEASED;
               ok       = 1'b1;
               rel_push = accept;
            end
         end
         default: begin
            status = ST_GRANTED;
         end
      endcase
   end

   // Next state.
   always_comb begin
      count_in        = count_ff;
      usable_in       = usable_ff;
      head_in         = head_ff;
      hvalid_in       = hvalid_ff;
      nxt_in          = nxt_ff;
      pend_in         = 1'b0;
      sweep_active_in = sweep_active_ff;
      sweep_in        = sweep_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = sweep_ff;
      mem_wr_data     = (sweep_next < eff_count) ? LINK_W'(sweep_next) : LINK_NULL;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = IDX_W'(nxt_ff);

      if (sweep_active_ff) begin
         // Rebuild: chain entry i to i+1 within the block count (null past it), and hold the list at block zero.
         mem_wr_en = 1'b1;
         head_in   = '0;
         hvalid_in = (eff_count != '0);
         nxt_in    = (EXT_W'(1) < eff_count) ? LINK_W'(1) : LINK_NULL;
         if (sweep_ff == LAST_IDX) begin
            sweep_active_in = 1'b0;
         end else begin
            sweep_in = sweep_ff + IDX_W'(1);
         end
      end

      if (pend_ff) begin
         nxt_in = mem_rd_data;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, status, (alloc_grant ? GRANT_W'(head_ff) : GRANT_W'(0)), ok};
      end

      if (alloc_grant) begin
         // Pop: advance the head and fetch the link of the new head.
         if (nxt_is_null) begin
            hvalid_in = 1'b0;
            head_in   = '0;
         end else begin
            head_in   = IDX_W'(nxt_ff);
            mem_rd_en = 1'b1;
            pend_in   = 1'b1;
         end
      end

      if (rel_push) begin
         // Push: the released block links to the old head and becomes the head.
         mem_wr_en   = 1'b1;
         mem_wr_addr = IDX_W'(rel_idx);
         mem_wr_data = push_link;
         head_in     = IDX_W'(rel_idx);
         hvalid_in   = 1'b1;
         nxt_in      = push_link;
      end

      if (cfg_wr) begin
         unique case (csr_paddr[2])
            REG_BLOCK_COUNT: begin
               count_in        = csr_pwdata[COUNT_W-1:0];
               sweep_active_in = 1'b1;
               sweep_in        = '0;
               pend_in         = 1'b0;   // drop any link read in flight
            end
            REG_USABLE: begin
               usable_in = csr_pwdata[BYTES_W-1:0];
            end
            default: begin
               usable_in = usable_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= COUNT_RESET;
         usable_ff       <= USABLE_RESET;
         pend_ff         <= 1'b0;
         sweep_active_ff <= 1'b1;
         sweep_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         head_ff         <= '0;
         hvalid_ff       <= 1'b0;
      end else begin
         count_ff        <= count_in;
         usable_ff       <= usable_in;
         pend_ff         <= pend_in;
         sweep_active_ff <= sweep_active_in;
         sweep_ff        <= sweep_in;
         rsp_valid_ff    <= rsp_valid_in;
         head_ff         <= head_in;
         hvalid_ff       <= hvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      nxt_ff      <= nxt_in;
      rsp_data_ff <= rsp_data_in;
   end

   fbfla_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? CSR_DATA_W'(usable_ff) : CSR_DATA_W'(count_ff);

`ifndef ASSERT_OFF
   // No request is taken while the link memory is being rebuilt.
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_active_ff |-> !req_tready)
      else $error("request taken during rebuild");

   // The link read of a new head must land before the next request.
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !req_tready)
      else $error("request taken while head link is pending");

   // A push always leaves a non-empty list with the pushed block at the head.
   a_push_head: assert property (@(posedge clock) disable iff (reset)
      rel_push && !cfg_wr |=> hvalid_ff && (head_ff == $past(IDX_W'(rel_idx))))
      else $error("push did not update head");

   // Popping the last block empties the list.
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      alloc_grant && nxt_is_null && !cfg_wr |=> !hvalid_ff)
      else $error("pop of last block left list non-empty");
`endif

endmodule

### rtl/fbfla_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fbfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
